// ===== src/sbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants for the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 5;
  localparam int ST_W            = 3;
  localparam int IMM_W           = 8;
  localparam int CFG_W           = 9;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int LOCAL_SLOTS_DEF = 256;

  localparam logic [CFG_W-1:0]  NUM_LOCALS_RST = 9'd256;
  localparam logic [DATA_W-1:0] MIN_INT        = 32'h8000_0000;
  localparam logic [DATA_W-1:0] NEG_ONE        = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_POP   = 5'd0,
    OP_DUP   = 5'd1,
    OP_SWAP  = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_MUL   = 5'd5,
    OP_DIV   = 5'd6,
    OP_REM   = 5'd7,
    OP_AND   = 5'd8,
    OP_OR    = 5'd9,
    OP_XOR   = 5'd10,
    OP_SHL   = 5'd11,
    OP_SHR   = 5'd12,
    OP_PUSHB = 5'd13,
    OP_PUSHZ = 5'd14,
    OP_LOAD  = 5'd15,
    OP_STORE = 5'd16,
    OP_RET   = 5'd17
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DIVZERO  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_UNDER    = 3'd3,
    ST_STACKOVF = 3'd4,
    ST_BADIDX   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RDB,
    S_RDA,
    S_LDW,
    S_EXEC,
    S_DIV,
    S_SWP2,
    S_TOP,
    S_TOPW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

// ===== src/sbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sbe_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_alu
// Shared arithmetic unit: combinational add/sub/mul/logic/shift, bit-serial
// signed divide and remainder, and operand error checks.
// ----------------------------------------------------------------------------
module sbe_alu
  import sbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] result,
  output status_t           err,
  output alu_stat_t         stat
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;
  logic              is_rem_r, is_rem_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] div_res;
  logic [DATA_W-1:0] mul_full;

  assign mul_full = a * b;
  assign trial    = {rem_r, quo_r[DATA_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign div_res  = is_rem_r ? (neg_r_r ? (~rem_r + 1'b1) : rem_r)
                             : (neg_q_r ? (~quo_r + 1'b1) : quo_r);

  always_comb begin
    err = ST_OK;
    case (ctrl.op)
      OP_DIV, OP_REM: begin
        if (b == '0) begin
          err = ST_DIVZERO;
        end else if (a == MIN_INT && b == NEG_ONE) begin
          err = ST_OVERFLOW;
        end
      end
      OP_SHL, OP_SHR: begin
        if (b > DATA_W'(31)) begin
          err = ST_BADIDX;
        end
      end
      default: err = ST_OK;
    endcase
  end

  always_comb begin
    case (ctrl.op)
      OP_ADD:         result = a + b;
      OP_SUB:         result = a - b;
      OP_MUL:         result = mul_full;
      OP_AND:         result = a & b;
      OP_OR:          result = a | b;
      OP_XOR:         result = a ^ b;
      OP_SHL:         result = a << b[4:0];
      OP_SHR:         result = $signed(a) >>> b[4:0];
      OP_DIV, OP_REM: result = div_res;
      default:        result = '0;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    is_rem_nxt = is_rem_r;
    if (ctrl.start) begin
      // work on magnitudes, fix signs at the end
      busy_nxt   = 1'b1;
      cnt_nxt    = CNT_W'(DATA_W);
      rem_nxt    = '0;
      quo_nxt    = a[DATA_W-1] ? (~a + 1'b1) : a;
      dvs_nxt    = b[DATA_W-1] ? (~b + 1'b1) : b;
      neg_q_nxt  = a[DATA_W-1] ^ b[DATA_W-1];
      neg_r_nxt  = a[DATA_W-1];
      is_rem_nxt = (ctrl.op == OP_REM);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_r_r  <= neg_r_nxt;
    is_rem_r <= is_rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== src/stack_bytecode_executor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_top
// Operand-stack interpreter core: one decoded instruction per input word.
// ----------------------------------------------------------------------------
// One instruction is executed at a time. Stack and local variables live in
// one-write, one-read memories with registered read data. S_CHK settles pop,
// pushes, unknown codes and errors found before the stack is read; dup, store
// and return read the top in S_RDB; load writes in S_LDW; swap and binary ops
// read both operands (S_RDB, S_RDA), then S_EXEC catches divide-by-zero,
// overflow and shift errors, swap ends in S_SWP2 and divide/remainder wait in
// S_DIV, the shared divider retiring one quotient bit per cycle. All then read
// the new top (S_TOP, S_TOPW) and load the result in S_FIN; the next word is
// accepted in the idle state that follows. A new word is taken while the
// previous result still waits on the output; a second result waits in the
// finish state until the output register frees up. Neither memory is cleared
// at reset; reading a local that was never stored gives garbage.
module stack_bytecode_executor_top
  import sbe_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int LOCAL_SLOTS = LOCAL_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [CFG_W-1:0]                     cfg_num_locals,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [OP_W-1:0]                      in_req_type,
  input  logic [IMM_W-1:0]                     in_immediate,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ST_W-1:0]                      out_status,
  output logic signed [DATA_W-1:0]             out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     out_stack_depth,
  output logic                                 out_finished,
  output logic signed [DATA_W-1:0]             out_return_value
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int LA_W = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [IMM_W-1:0]  imm_r, imm_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [CFG_W-1:0]  num_locals_r;
  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] ret_r, ret_nxt;
  status_t           st_r, st_nxt;
  logic              fin_r, fin_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_top_r, out_top_nxt;
  logic [SP_W-1:0]   out_depth_r, out_depth_nxt;
  logic              out_fin_r, out_fin_nxt;
  logic [DATA_W-1:0] out_ret_r, out_ret_nxt;

  logic              s_we;
  logic [SA_W-1:0]   s_waddr, s_raddr;
  logic [DATA_W-1:0] s_wdata, s_rdata;
  logic              l_we;
  logic [LA_W-1:0]   l_addr;
  logic [DATA_W-1:0] l_rdata;

  alu_ctrl_t         alu_ctrl;
  alu_stat_t         alu_stat;
  logic [DATA_W-1:0] alu_result;
  status_t           alu_err;

  logic [SA_W-1:0]   sp_a, sp_m1, sp_m2;
  logic              idx_ok, has1, has2, full;
  logic              out_free;

  assign sp_a   = sp_r[SA_W-1:0];
  assign sp_m1  = SA_W'(sp_r - SP_W'(1));
  assign sp_m2  = SA_W'(sp_r - SP_W'(2));
  assign has1   = (sp_r >= SP_W'(1));
  assign has2   = (sp_r >= SP_W'(2));
  assign full   = (sp_r >= SP_W'(STACK_DEPTH));
  assign idx_ok = ({1'b0, imm_r} < num_locals_r) &&
                  ({1'b0, imm_r} < CFG_W'(LOCAL_SLOTS));
  assign l_addr = imm_r[LA_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  sbe_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sbe_ram #(.WIDTH(DATA_W), .DEPTH(LOCAL_SLOTS)) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_addr),
    .wdata (s_rdata),
    .raddr (l_addr),
    .rdata (l_rdata)
  );

  sbe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (alu_ctrl),
    .a      (a_r),
    .b      (b_r),
    .result (alu_result),
    .err    (alu_err),
    .stat   (alu_stat)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    imm_nxt        = imm_r;
    sp_nxt         = sp_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    top_nxt        = top_r;
    ret_nxt        = ret_r;
    st_nxt         = st_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_fin_nxt    = out_fin_r;
    out_ret_nxt    = out_ret_r;
    s_we           = 1'b0;
    s_waddr        = sp_a;
    s_wdata        = alu_result;
    s_raddr        = sp_m1;
    l_we           = 1'b0;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = op_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_req_type);
          imm_nxt   = in_immediate;
          st_nxt    = ST_OK;
          fin_nxt   = 1'b0;
          ret_nxt   = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = S_TOP;
        case (op_r)
          OP_POP: begin
            if (!has1) st_nxt = ST_UNDER;
            else sp_nxt = sp_r - 1'b1;
          end
          OP_DUP: begin
            if (!has1) st_nxt = ST_UNDER;
            else if (full) st_nxt = ST_STACKOVF;
            else state_nxt = S_RDB;
          end
          OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM,
          OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
            if (!has2) st_nxt = ST_UNDER;
            else state_nxt = S_RDB;
          end
          OP_PUSHB, OP_PUSHZ: begin
            if (full) begin
              st_nxt = ST_STACKOVF;
            end else begin
              s_we    = 1'b1;
              s_wdata = (op_r == OP_PUSHB) ? {{(DATA_W-IMM_W){imm_r[IMM_W-1]}}, imm_r}
                                           : '0;
              sp_nxt  = sp_r + 1'b1;
            end
          end
          OP_LOAD: begin
            if (full) st_nxt = ST_STACKOVF;
            else if (!idx_ok) st_nxt = ST_BADIDX;
            else state_nxt = S_LDW;
          end
          OP_STORE: begin
            if (!has1) st_nxt = ST_UNDER;
            else if (!idx_ok) st_nxt = ST_BADIDX;
            else state_nxt = S_RDB;
          end
          OP_RET: begin
            if (!has1) st_nxt = ST_UNDER;
            else state_nxt = S_RDB;
          end
          default: state_nxt = S_TOP;
        endcase
      end
      S_RDB: begin
        // top of stack is on the read port now
        b_nxt     = s_rdata;
        state_nxt = S_TOP;
        case (op_r)
          OP_DUP: begin
            s_we    = 1'b1;
            s_wdata = s_rdata;
            sp_nxt  = sp_r + 1'b1;
          end
          OP_STORE: begin
            l_we   = 1'b1;
            sp_nxt = sp_r - 1'b1;
          end
          OP_RET: begin
            ret_nxt = s_rdata;
            fin_nxt = 1'b1;
            sp_nxt  = sp_r - 1'b1;
          end
          default: begin
            s_raddr   = sp_m2;
            state_nxt = S_RDA;
          end
        endcase
      end
      S_RDA: begin
        a_nxt     = s_rdata;
        state_nxt = S_EXEC;
      end
      S_LDW: begin
        s_we      = 1'b1;
        s_wdata   = l_rdata;
        sp_nxt    = sp_r + 1'b1;
        state_nxt = S_TOP;
      end
      S_EXEC: begin
        if (op_r == OP_SWAP) begin
          s_we      = 1'b1;
          s_waddr   = sp_m1;
          s_wdata   = a_r;
          state_nxt = S_SWP2;
        end else if (alu_err != ST_OK) begin
          st_nxt    = alu_err;
          state_nxt = S_TOP;
        end else if (op_r == OP_DIV || op_r == OP_REM) begin
          alu_ctrl.start = 1'b1;
          state_nxt      = S_DIV;
        end else begin
          s_we      = 1'b1;
          s_waddr   = sp_m2;
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_TOP;
        end
      end
      S_DIV: begin
        if (alu_stat.done) begin
          s_we      = 1'b1;
          s_waddr   = sp_m2;
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_TOP;
        end
      end
      S_SWP2: begin
        s_we      = 1'b1;
        s_waddr   = sp_m2;
        s_wdata   = b_r;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        // read the new top with the updated pointer
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        top_nxt   = has1 ? s_rdata : '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_top_nxt    = top_r;
          out_depth_nxt  = sp_r;
          out_fin_nxt    = fin_r;
          out_ret_nxt    = ret_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      num_locals_r <= NUM_LOCALS_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        num_locals_r <= cfg_num_locals;
      end
    end
    op_r         <= op_nxt;
    imm_r        <= imm_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    top_r        <= top_nxt;
    ret_r        <= ret_nxt;
    st_r         <= st_nxt;
    fin_r        <= fin_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_fin_r    <= out_fin_nxt;
    out_ret_r    <= out_ret_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_top_value    = out_top_r;
  assign out_stack_depth  = out_depth_r;
  assign out_finished     = out_fin_r;
  assign out_return_value = out_ret_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside finish state");

  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_status_r == ST_OK)
    else $error("return flagged with error status");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_stat.done |-> state_r == S_DIV)
    else $error("divider done outside divide wait");

endmodule
